[sv/rar_pkg.sv]
// ============================================================================
// rar_pkg
// Shared types and codes for the rational arithmetic reduce unit.
// ============================================================================
package rar_pkg;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_ZERO_DEN = 2'd1,
        STAT_OVERFLOW = 2'd2
    } t_status;

    localparam int FIELD_W = 32;
    localparam int MAG_W   = 64;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [FIELD_W-1:0] left_num;
        logic signed [FIELD_W-1:0] left_den;
        logic signed [FIELD_W-1:0] right_num;
        logic signed [FIELD_W-1:0] right_den;
    } t_in_word;

    typedef struct packed {
        logic signed [63:0] result_num;
        logic [62:0]        result_den;
        logic [1:0]         status;
    } t_out_word;

    // Classified job handed from front to back
    typedef struct packed {
        logic             err;
        logic [MAG_W-1:0] num;
        logic [MAG_W-1:0] den;
        logic             neg;
    } t_job;

endpackage

[sv/rational_arith_reduce_unit.sv]
// ============================================================================
// rational_arith_reduce_unit
// Adds, subtracts, multiplies or divides two fractions and reduces to
// lowest terms.
// ============================================================================
// Sequence: front capture, multiply, combine and push, then binary gcd steps,
// 128 division steps (64 per quotient), the output state and the registered word.
// Throughput: one word per back-end pass; a 2-entry queue lets the front
// accept the next word while the back reduces. The receiver cannot stall.
// Reset: synchronous active low, clears control state; queue empty.
module rational_arith_reduce_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  rar_pkg::t_in_word   i_word,
    output logic                o_strobe,
    output rar_pkg::t_out_word  o_word
);
    logic          push, pop, full, empty;
    rar_pkg::t_job f_job, q_job;

    rar_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_word(i_word),
        .i_full(full), .o_busy(busy), .o_push(push), .o_job(f_job)
    );

    rar_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(f_job),
        .i_pop(pop), .o_full(full), .o_empty(empty), .o_job(q_job)
    );

    rar_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_job(q_job),
        .o_pop(pop), .o_strobe(o_strobe), .o_word(o_word)
    );

    // Queue never overfills or underflows
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !(push && !pop)) else $error("queue overfill");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty) else $error("queue underflow");
    // A strobe is a single pulse
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("strobe held");
endmodule

[sv/rar_front.sv]
// ============================================================================
// rar_front
// Takes one word, forms cross products in registered steps (multiply, then
// combine), classifies it and pushes a job (magnitudes and sign) into the queue.
// ============================================================================
module rar_front #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  rar_pkg::t_in_word i_word,
    input  logic              i_full,
    output logic              o_busy,
    output logic              o_push,
    output rar_pkg::t_job     o_job
);
    localparam int W = OPERAND_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_SUM  = 4'b0100,
        S_PUSH = 4'b1000
    } t_fstate;

    t_fstate r_state, n_state;
    logic [1:0]   r_mode;
    logic [W:0]   r_lnm, r_ldm, r_rnm, r_rdm;
    logic         r_lnn, r_ldn, r_rnn, r_rdn;
    logic [63:0]  r_p0, r_p1, r_p2;
    rar_pkg::t_job r_job;

    function automatic logic [W:0] mag(input logic [31:0] v);
        logic [W-1:0] s;
        s = v[W-1:0];
        if (s[W-1]) mag = {1'b0, ~s} + (W+1)'(1);
        else        mag = {1'b0, s};
    endfunction

    assign o_busy = (r_state != S_IDLE);
    assign o_push = (r_state == S_PUSH) && !i_full;
    assign o_job  = r_job;

    // Select multiplier operands by mode
    logic [W:0] m0a, m0b, m1a, m1b;
    always_comb begin
        m0a = r_lnm; m0b = r_rdm;
        m1a = r_ldm; m1b = r_rnm;
        if (r_mode == rar_pkg::MODE_MUL) begin
            m0b = r_rnm; m1b = r_rdm;
        end
    end

    // Combine products into signed numerator
    logic        an, bn, nneg, dneg;
    logic [63:0] num;
    always_comb begin
        an   = (r_lnn != r_rdn) && (r_p0 != 64'd0);
        bn   = (r_ldn != r_rnn) && (r_p1 != 64'd0);
        if (r_mode == rar_pkg::MODE_SUB && r_p1 != 64'd0) bn = !bn;
        num  = r_p0;
        nneg = r_lnn != r_rdn;
        dneg = r_ldn != r_rdn;
        case (r_mode)
            rar_pkg::MODE_ADD, rar_pkg::MODE_SUB: begin
                if (an == bn) begin
                    num = r_p0 + r_p1; nneg = an;
                end else if (r_p0 >= r_p1) begin
                    num = r_p0 - r_p1; nneg = an;
                end else begin
                    num = r_p1 - r_p0; nneg = bn;
                end
            end
            rar_pkg::MODE_MUL: nneg = r_lnn != r_rnn;
            default: begin
                nneg = r_lnn != r_rdn;
                dneg = r_ldn != r_rnn;
            end
        endcase
    end

    // Sequence: capture, multiply, combine, push
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_MUL;
            S_MUL:  n_state = S_SUM;
            S_SUM:  n_state = S_PUSH;
            S_PUSH: if (!i_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_mode <= i_word.mode;
            r_lnm  <= mag(i_word.left_num);  r_lnn <= i_word.left_num[W-1];
            r_ldm  <= mag(i_word.left_den);  r_ldn <= i_word.left_den[W-1];
            r_rnm  <= mag(i_word.right_num); r_rnn <= i_word.right_num[W-1];
            r_rdm  <= mag(i_word.right_den); r_rdn <= i_word.right_den[W-1];
        end
        if (r_state == S_MUL) begin
            r_p0 <= 64'(m0a * m0b);
            r_p1 <= 64'(m1a * m1b);
            r_p2 <= 64'(r_ldm * ((r_mode == rar_pkg::MODE_DIV) ? r_rnm : r_rdm));
        end
        if (r_state == S_SUM) begin
            r_job.err <= (r_ldm == '0) || (r_rdm == '0)
                      || (r_mode == rar_pkg::MODE_DIV && r_rnm == '0);
            r_job.num <= num;
            r_job.den <= r_p2;
            r_job.neg <= nneg ^ dneg;
        end
    end
endmodule

[sv/rar_queue.sv]
// ============================================================================
// rar_queue
// Two-entry job queue between front and back.
// ============================================================================
module rar_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rar_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output rar_pkg::t_job o_job
);
    rar_pkg::t_job r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end
endmodule

[sv/rar_back.sv]
// ============================================================================
// rar_back
// Reduces one job: binary gcd, then two restoring divisions by the gcd.
// ============================================================================
module rar_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  rar_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_strobe,
    output rar_pkg::t_out_word o_word
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_GCD  = 5'b00010,
        S_DIVN = 5'b00100,
        S_DIVD = 5'b01000,
        S_OUT  = 5'b10000
    } t_bstate;

    t_bstate     r_state, n_state;
    logic [63:0] r_num, r_den, r_a, r_b, r_g, r_q, r_rem, r_qn;
    logic [5:0]  r_sh;
    logic [5:0]  r_cnt;
    logic        r_neg, r_err, r_zero;
    logic        r_strobe;
    rar_pkg::t_out_word r_word;

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign o_strobe = r_strobe;
    assign o_word   = r_word;

    // One restoring division step
    logic [64:0] rem_sh;
    logic [63:0] div_src;
    logic        fits;
    logic [63:0] rem_nx;
    assign div_src = (r_state == S_DIVN) ? r_num : r_den;
    assign rem_sh  = {r_rem, div_src[6'd63 - r_cnt]};
    assign fits    = (rem_sh >= {1'b0, r_g});
    assign rem_nx  = fits ? 64'(rem_sh - {1'b0, r_g}) : rem_sh[63:0];

    logic last;
    assign last = (r_cnt == 6'd63);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (!i_empty) n_state = S_GCD;
            S_GCD: begin
                if (r_err || r_zero)   n_state = S_OUT;
                else if (r_a == r_b)   n_state = S_DIVN;
            end
            S_DIVN: if (last) n_state = S_DIVD;
            S_DIVD: if (last) n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_OUT);
        end
    end

    // Datapath: load the job, strip common twos, subtract-and-shift gcd, then shift in quotient bits
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_num  <= i_job.num;
                r_den  <= i_job.den;
                r_a    <= i_job.num;
                r_b    <= i_job.den;
                r_neg  <= i_job.neg;
                r_err  <= i_job.err;
                r_zero <= (i_job.num == 64'd0);
                r_sh   <= 6'd0;
            end
            S_GCD: begin
                if (r_a != r_b) begin
                    if (!r_a[0] && !r_b[0]) begin
                        r_a <= r_a >> 1; r_b <= r_b >> 1; r_sh <= r_sh + 6'd1;
                    end else if (!r_a[0]) r_a <= r_a >> 1;
                    else if (!r_b[0])     r_b <= r_b >> 1;
                    else if (r_a > r_b)   r_a <= (r_a - r_b) >> 1;
                    else                  r_b <= (r_b - r_a) >> 1;
                end else begin
                    r_g <= r_a << r_sh;
                end
                r_cnt <= 6'd0;
                r_rem <= 64'd0;
            end
            S_DIVN, S_DIVD: begin
                r_q <= {r_q[62:0], fits};
                if (last) begin
                    r_cnt <= 6'd0;
                    r_rem <= 64'd0;
                    if (r_state == S_DIVN) r_qn <= {r_q[62:0], fits};
                end else begin
                    r_cnt <= r_cnt + 6'd1;
                    r_rem <= rem_nx;
                end
            end
            default: ;
        endcase
    end

    // Format the result word
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT) begin
            if (r_err) begin
                r_word <= '{64'sd0, 63'd0, rar_pkg::STAT_ZERO_DEN};
            end else if (r_zero) begin
                r_word <= '{64'sd0, 63'd1, rar_pkg::STAT_OK};
            end else if (!r_neg && r_qn[63]) begin
                r_word <= '{64'sd0, 63'd0, rar_pkg::STAT_OVERFLOW};
            end else begin
                r_word.result_num <= r_neg ? (~r_qn + 64'd1) : r_qn;
                r_word.result_den <= r_q[62:0];
                r_word.status     <= rar_pkg::STAT_OK;
            end
        end
    end
endmodule
